[hdl/adpt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Presence table package
// Item types, table entry layout and shared constants of the presence table.
// ---------------------------------------------------------------------------
package adpt_pkg;

  localparam int KEY_W       = 29;
  localparam int TIME_W      = 32;
  localparam int LINK_W      = 25;
  localparam int TIMEOUT_W   = 16;
  localparam int IDX_OUT_W   = 5;
  localparam int COUNT_OUT_W = 6;

  localparam int DEFAULT_TABLE_DEPTH = 32;
  localparam logic [TIMEOUT_W-1:0] DEFAULT_TIMEOUT_MS = 16'd5000;

  localparam logic OP_MESSAGE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  localparam logic [7:0] CMD_STATUS_REPORT = 8'd0;

  typedef struct packed {
    logic        operation;
    logic [6:0]  zone;
    logic [7:0]  high_address;
    logic [5:0]  low_address;
    logic [7:0]  device_type;
    logic        from_device;
    logic        is_controller_type;
    logic [7:0]  command_byte;
    logic [7:0]  link_mask_byte;
    logic [7:0]  link_state_byte;
    logic [7:0]  supply_volts_byte;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic                   hit;
    logic                   inserted;
    logic                   dropped_full;
    logic [IDX_OUT_W-1:0]   entry_index;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic [COUNT_OUT_W-1:0] expired_count;
  } out_item_t;

  // Link status: valid flag, supply byte, link state byte, link mask byte.
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] last_seen;
    logic [LINK_W-1:0] link;
  } entry_t;

endpackage

`default_nettype wire

[hdl/active_device_presence_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Active device presence table
// Table of controller devices seen on the bus, with refresh and ageing.
// ---------------------------------------------------------------------------
// Usage:
//   An input transfer on in_valid/in_stall carries either a received message
//   or an ageing tick; every input transfer yields exactly one result transfer
//   on out_valid/out_stall. cfg_wr_en writes the offline timeout in ms; it
//   must be written only while no item is in flight; the user is bound by
//   this, as the block itself does not enforce it. An item that touches the
//   table walks the used entries through the single read port of the entry
//   memory, one entry per cycle, and a message stops at its key; the result
//   then passes through the done state into the output register. A message
//   that is not tracked goes straight from idle to the done state.
//   One item is processed at a time; in_stall is high while it is in work.
//   The next item can be taken once its result is in the output register.
//   A finished result waits in the output register, so the next item can be
//   taken while the receiver stalls; a further result then waits in the
//   engine until the output register drains.
//   Reset empties the table and restores the timeout to 5000 ms; no clearing
//   pass is needed because only entries below the fill count are ever read.
// ---------------------------------------------------------------------------
module active_device_presence_table
  import adpt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data,
  input  wire logic                 cfg_wr_en,
  input  wire logic [TIMEOUT_W-1:0] cfg_wr_data
);

  logic [TIMEOUT_W-1:0] timeout_r;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r;
  logic                 busy;
  logic                 res_valid;
  out_item_t            res;
  logic                 res_free;
  logic                 start;

  assign in_stall = busy;
  assign start    = in_valid & ~busy;
  assign res_free = ~out_valid_r | ~out_stall;

  adpt_engine #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .item     (in_data),
    .timeout  (timeout_r),
    .res_free (res_free),
    .busy     (busy),
    .res_valid(res_valid),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= DEFAULT_TIMEOUT_MS;
    end else if (cfg_wr_en) begin
      timeout_r <= cfg_wr_data;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // An accepted item keeps the input side stalled while it is being worked on.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item was still in work");

  // A result never reports more than one outcome of a message.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($countones({out_data.hit, out_data.inserted,
                               out_data.dropped_full}) <= 1))
    else $error("result reports conflicting outcomes");

  // A device is only dropped when every entry is in use.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.dropped_full) |->
      (out_data.entry_count == COUNT_OUT_W'(TABLE_DEPTH)))
    else $error("device dropped while the table had room");

endmodule

`default_nettype wire

[hdl/adpt_entry_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Presence table entry memory
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module adpt_entry_mem
  import adpt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
  localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire entry_t           wr_data,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output entry_t                rd_q
);

  entry_t entry_mem [TABLE_DEPTH];
  entry_t rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= entry_mem[rd_addr];
    end
  end

  assign rd_q = rd_q_r;

endmodule

`default_nettype wire

[hdl/adpt_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Presence table scan engine
// Walks the used entries one per cycle, refreshing, inserting or ageing them.
// ---------------------------------------------------------------------------
module adpt_engine
  import adpt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
  localparam int IDX_W = $clog2(TABLE_DEPTH),
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire in_item_t             item,
  input  wire logic [TIMEOUT_W-1:0] timeout,
  input  wire logic                 res_free,
  output logic                      busy,
  output logic                      res_valid,
  output out_item_t                 res
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

  logic [1:0]             state_r, state_nxt;
  in_item_t               item_r, item_nxt;
  logic [CNT_W-1:0]       rd_cnt_r, rd_cnt_nxt;
  logic                   rd_v_r, rd_v_nxt;
  logic [IDX_W-1:0]       rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]       used_r, used_nxt;
  logic [TABLE_DEPTH-1:0] online_r, online_nxt;
  logic                   hit_r, hit_nxt;
  logic                   ins_r, ins_nxt;
  logic                   drop_r, drop_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [CNT_W-1:0]       exp_r, exp_nxt;

  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  entry_t           mem_wr_data;
  logic             mem_rd_en;
  logic [IDX_W-1:0] mem_rd_addr;
  entry_t           mem_q;

  logic [KEY_W-1:0]  key;
  logic              is_tick;
  logic              do_refresh;
  logic              do_report;
  logic [LINK_W-1:0] report;
  logic [TIME_W-1:0] elapsed;
  logic              expire;
  logic              match;
  logic              start_scan;

  adpt_entry_mem #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_entry_mem (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_q   (mem_q)
  );

  assign key        = {item_r.zone, item_r.high_address, item_r.low_address,
                       item_r.device_type};
  assign is_tick    = (item_r.operation == OP_TICK);
  assign do_refresh = item_r.from_device & item_r.is_controller_type;
  assign do_report  = item_r.is_controller_type &
                      (item_r.command_byte == CMD_STATUS_REPORT);
  assign report     = {1'b1, item_r.supply_volts_byte, item_r.link_state_byte,
                       item_r.link_mask_byte};
  assign elapsed    = item_r.now_ms - mem_q.last_seen;
  assign expire     = rd_v_r & is_tick & online_r[rd_idx_r] &
                      (elapsed > {{(TIME_W - TIMEOUT_W){1'b0}}, timeout});
  assign match      = rd_v_r & ~is_tick & (mem_q.key == key);
  assign start_scan = (item.operation == OP_TICK) |
                      (item.is_controller_type &
                       (item.from_device | (item.command_byte == CMD_STATUS_REPORT)));

  // The compare stage always works on the entry read in the previous cycle, so
  // a write-back never targets the entry being read in the same cycle.
  assign mem_rd_en   = (state_r == ST_SCAN) && (rd_cnt_r != used_r);
  assign mem_rd_addr = rd_cnt_r[IDX_W-1:0];

  always_comb begin
    state_nxt   = state_r;
    item_nxt    = item_r;
    rd_cnt_nxt  = rd_cnt_r;
    rd_v_nxt    = 1'b0;
    rd_idx_nxt  = rd_idx_r;
    used_nxt    = used_r;
    online_nxt  = online_r;
    hit_nxt     = hit_r;
    ins_nxt     = ins_r;
    drop_nxt    = drop_r;
    idx_nxt     = idx_r;
    exp_nxt     = exp_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = rd_idx_r;
    mem_wr_data = mem_q;
    res_valid   = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          item_nxt   = item;
          rd_cnt_nxt = '0;
          hit_nxt    = 1'b0;
          ins_nxt    = 1'b0;
          drop_nxt   = 1'b0;
          idx_nxt    = '0;
          exp_nxt    = '0;
          state_nxt  = start_scan ? ST_SCAN : ST_DONE;
        end
      end

      ST_SCAN: begin
        if (mem_rd_en) begin
          rd_cnt_nxt = rd_cnt_r + 1'b1;
          rd_v_nxt   = 1'b1;
          rd_idx_nxt = mem_rd_addr;
        end

        if (expire) begin
          mem_wr_en              = 1'b1;
          mem_wr_data.link       = '0;
          online_nxt[rd_idx_r]   = 1'b0;
          exp_nxt                = exp_r + 1'b1;
        end

        if (match) begin
          state_nxt = ST_DONE;
          if (do_refresh) begin
            hit_nxt                = 1'b1;
            idx_nxt                = rd_idx_r;
            mem_wr_en              = 1'b1;
            mem_wr_data.last_seen  = item_r.now_ms;
            online_nxt[rd_idx_r]   = 1'b1;
            if (do_report) begin
              mem_wr_data.link = report;
            end
          end else if (online_r[rd_idx_r]) begin
            mem_wr_en        = 1'b1;
            mem_wr_data.link = report;
          end
        end else if (!rd_v_r && (rd_cnt_r == used_r)) begin
          // Walk finished without a key match.
          state_nxt = ST_DONE;
          if (!is_tick && do_refresh) begin
            if (used_r != FULL_COUNT) begin
              mem_wr_en                    = 1'b1;
              mem_wr_addr                  = used_r[IDX_W-1:0];
              mem_wr_data.key              = key;
              mem_wr_data.last_seen        = item_r.now_ms;
              mem_wr_data.link             = do_report ? report : '0;
              online_nxt[used_r[IDX_W-1:0]] = 1'b1;
              used_nxt                     = used_r + 1'b1;
              ins_nxt                      = 1'b1;
              idx_nxt                      = used_r[IDX_W-1:0];
            end else begin
              drop_nxt = 1'b1;
            end
          end
        end
      end

      ST_DONE: begin
        if (res_free) begin
          res_valid = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_v_r   <= 1'b0;
      used_r   <= '0;
      online_r <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_v_r   <= rd_v_nxt;
      used_r   <= used_nxt;
      online_r <= online_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    rd_cnt_r <= rd_cnt_nxt;
    rd_idx_r <= rd_idx_nxt;
    hit_r    <= hit_nxt;
    ins_r    <= ins_nxt;
    drop_r   <= drop_nxt;
    idx_r    <= idx_nxt;
    exp_r    <= exp_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign res.hit           = hit_r;
  assign res.inserted      = ins_r;
  assign res.dropped_full  = drop_r;
  assign res.entry_index   = IDX_OUT_W'(idx_r);
  assign res.entry_count   = COUNT_OUT_W'(used_r);
  assign res.expired_count = COUNT_OUT_W'(exp_r);

endmodule

`default_nettype wire
